// ===== sv/fbm_pkg.sv =====
// ----------------------------------------------------------------------------
// fbm_pkg: shared types and constants for the fractal value noise block
// sequencer state encoding and fixed-point constants
// ----------------------------------------------------------------------------
package fbm_pkg;

    localparam int unsigned NOISE_W = 17;   // q1.16 noise value
    localparam int unsigned CFG_W   = 16;   // widest config register
    localparam int unsigned IDX_W   = 2;    // config register index

    // config register indexes
    localparam logic [IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_LACUNARITY   = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAIN         = 2'd2;

    // hash constants
    localparam logic [31:0] HASH_MX = 32'd1619;
    localparam logic [31:0] HASH_MY = 32'd31337;
    localparam logic [31:0] HASH_M2 = 32'd15731;
    localparam logic [31:0] HASH_A1 = 32'd789221;
    localparam logic [31:0] HASH_A2 = 32'd1376312589;
    localparam int unsigned HASH_SH = 13;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [17:0] THREE_Q16 = 18'd196608;
    localparam logic [31:0] FREQ_ONE  = 32'd4096;
    localparam logic [15:0] AMP_ONE   = 16'd32768;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_SX1,
        ST_SX2,
        ST_SY1,
        ST_SY2,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_H5,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_B3,
        ST_B4,
        ST_B5,
        ST_B6,
        ST_ACC,
        ST_NX,
        ST_NF,
        ST_DONE
    } t_seq_state;

endpackage

// ===== sv/fbm_div_cell.sv =====
// ----------------------------------------------------------------------------
// fbm_div_cell: one restoring division step
// compares the remainder with the shifted divisor and hands both to the next cell
// ----------------------------------------------------------------------------
module fbm_div_cell #(
    parameter int unsigned SUM_W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [SUM_W-1:0]            i_rem,
    input  logic [SUM_W-1:0]            i_dsh,
    input  logic [fbm_pkg::NOISE_W-1:0] i_q,
    output logic                        o_vld,
    output logic [SUM_W-1:0]            o_rem,
    output logic [SUM_W-1:0]            o_dsh,
    output logic [fbm_pkg::NOISE_W-1:0] o_q
);
    import fbm_pkg::*;

    logic                 r_vld;
    logic [SUM_W-1:0]     r_rem;
    logic [SUM_W-1:0]     r_dsh;
    logic [NOISE_W-1:0]   r_q;
    logic                 n_bit;

    assign n_bit = (i_rem >= i_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_bit ? (i_rem - i_dsh) : i_rem;
        r_dsh <= i_dsh >> 1;
        r_q   <= {i_q[NOISE_W-2:0], n_bit};
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_dsh = r_dsh;
    assign o_q   = r_q;

endmodule

// ===== sv/fbm_oct_seq.sv =====
// ----------------------------------------------------------------------------
// fbm_oct_seq: octave sequencer
// walks the octaves over one shared registered multiplier and accumulates
// the weighted noise sum and the amplitude total
// ----------------------------------------------------------------------------
module fbm_oct_seq #(
    parameter int unsigned MAX_OCTAVES     = 8,
    parameter int unsigned COORD_FRAC_BITS = 16,
    parameter int unsigned OCT_W           = 4,
    parameter int unsigned AMP_W           = 24,
    parameter int unsigned TOT_W           = 28,
    parameter int unsigned SUM_W           = 45
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [31:0]       i_pos_x,
    input  logic signed [31:0]       i_pos_y,
    input  logic [OCT_W-1:0]         i_count,
    input  logic [15:0]              i_lacunarity,
    input  logic [15:0]              i_gain,
    output logic                     o_done,
    output logic [SUM_W-1:0]         o_sum,
    output logic [TOT_W-1:0]         o_tot
);
    import fbm_pkg::*;

    localparam int unsigned CF = COORD_FRAC_BITS;

    t_seq_state r_state, n_state;

    logic signed [31:0]  r_px, r_py;
    logic [31:0]         r_freq;
    logic [AMP_W-1:0]    r_amp;
    logic [SUM_W-1:0]    r_sum;
    logic [TOT_W-1:0]    r_tot;
    logic [OCT_W-1:0]    r_cnt, r_oct;
    logic [15:0]         r_lac, r_gain;
    logic [31:0]         r_ix, r_iy;
    logic [15:0]         r_fx, r_fy;
    logic [16:0]         r_sx, r_sy;
    logic [31:0]         r_t, r_n;
    logic [16:0]         r_c [4];
    logic [1:0]          r_k;
    logic [33:0]         r_acc;
    logic [16:0]         r_a, r_b;
    logic signed [67:0]  r_p;

    logic signed [33:0]  ma, mb;
    logic [31:0]         cx, cy;
    logic [31:0]         cell_v;
    logic [CF+15:0]      frac_ext;
    logic [15:0]         frac_v;
    logic [31:0]         n_sum32, n_mix;
    logic [31:0]         h_v;
    logic [16:0]         sum_hi;

    // lattice cell and q0.16 fraction of the last coordinate product
    assign cell_v   = r_p[12+CF+31:12+CF];
    assign frac_ext = {r_p[11+CF:12], 16'b0};
    assign frac_v   = frac_ext[CF+15:CF];

    assign cx      = r_ix + {31'b0, r_k[0]};
    assign cy      = r_iy + {31'b0, r_k[1]};
    assign n_sum32 = r_t + r_p[31:0];
    assign n_mix   = n_sum32 ^ {{HASH_SH{n_sum32[31]}}, n_sum32[31:HASH_SH]};
    assign h_v     = (r_p[31:0] + HASH_A2) & 32'h7fff_ffff;
    assign sum_hi  = 17'((34'(r_acc) + 34'(r_p[33:0])) >> 16);

    // multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            ST_CX:  begin ma = 34'(r_px); mb = {2'b0, r_freq}; end
            ST_CY:  begin ma = 34'(r_py); mb = {2'b0, r_freq}; end
            ST_SX1: begin ma = {18'b0, r_fx}; mb = {18'b0, r_fx}; end
            ST_SX2: begin
                ma = {18'b0, r_p[31:16]};
                mb = {16'b0, THREE_Q16 - {1'b0, r_fx, 1'b0}};
            end
            ST_SY1: begin ma = {18'b0, r_fy}; mb = {18'b0, r_fy}; end
            ST_SY2: begin
                ma = {18'b0, r_p[31:16]};
                mb = {16'b0, THREE_Q16 - {1'b0, r_fy, 1'b0}};
            end
            ST_H0:  begin ma = {2'b0, cx}; mb = {2'b0, HASH_MX}; end
            ST_H1:  begin ma = {2'b0, cy}; mb = {2'b0, HASH_MY}; end
            ST_H2:  begin ma = {2'b0, n_mix}; mb = {2'b0, n_mix}; end
            ST_H3:  begin ma = {2'b0, r_p[31:0]}; mb = {2'b0, HASH_M2}; end
            ST_H4:  begin ma = {2'b0, r_n}; mb = {2'b0, r_p[31:0] + HASH_A1}; end
            ST_B0:  begin ma = {17'b0, r_c[0]}; mb = {17'b0, ONE_Q16 - r_sx}; end
            ST_B1:  begin ma = {17'b0, r_c[1]}; mb = {17'b0, r_sx}; end
            ST_B2:  begin ma = {17'b0, r_c[2]}; mb = {17'b0, ONE_Q16 - r_sx}; end
            ST_B3:  begin ma = {17'b0, r_c[3]}; mb = {17'b0, r_sx}; end
            ST_B4:  begin ma = {17'b0, r_a}; mb = {17'b0, ONE_Q16 - r_sy}; end
            ST_B5:  begin ma = {17'b0, r_b}; mb = {17'b0, r_sy}; end
            ST_B6:  begin ma = {17'b0, sum_hi}; mb = 34'(r_amp); end
            ST_ACC: begin ma = 34'(r_amp); mb = {18'b0, r_gain}; end
            ST_NX:  begin ma = {2'b0, r_freq}; mb = {18'b0, r_lac}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_CX;
            ST_CX:   n_state = ST_CY;
            ST_CY:   n_state = ST_SX1;
            ST_SX1:  n_state = ST_SX2;
            ST_SX2:  n_state = ST_SY1;
            ST_SY1:  n_state = ST_SY2;
            ST_SY2:  n_state = ST_H0;
            ST_H0:   n_state = ST_H1;
            ST_H1:   n_state = ST_H2;
            ST_H2:   n_state = ST_H3;
            ST_H3:   n_state = ST_H4;
            ST_H4:   n_state = ST_H5;
            ST_H5:   n_state = (r_k == 2'd3) ? ST_B0 : ST_H0;
            ST_B0:   n_state = ST_B1;
            ST_B1:   n_state = ST_B2;
            ST_B2:   n_state = ST_B3;
            ST_B3:   n_state = ST_B4;
            ST_B4:   n_state = ST_B5;
            ST_B5:   n_state = ST_B6;
            ST_B6:   n_state = ST_ACC;
            ST_ACC:  n_state = ST_NX;
            ST_NX:   n_state = ST_NF;
            ST_NF:   n_state = (r_oct + 1'b1 == r_cnt) ? ST_DONE : ST_CX;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_p <= ma * mb;
        case (r_state)
            ST_IDLE: begin
                r_px   <= i_pos_x;
                r_py   <= i_pos_y;
                r_cnt  <= i_count;
                r_lac  <= i_lacunarity;
                r_gain <= i_gain;
                r_freq <= FREQ_ONE;
                r_amp  <= AMP_W'(AMP_ONE);
                r_sum  <= '0;
                r_tot  <= '0;
                r_oct  <= '0;
            end
            ST_CY:  begin r_ix <= cell_v; r_fx <= frac_v; end
            ST_SX1: begin r_iy <= cell_v; r_fy <= frac_v; end
            ST_SY1: r_sx <= r_p[32:16];
            ST_SY2: r_k  <= 2'd0;
            ST_H0:  r_sy <= (r_k == 2'd0) ? r_p[32:16] : r_sy;
            ST_H1:  r_t  <= r_p[31:0];
            ST_H2:  r_n  <= n_mix;
            ST_H5: begin
                r_c[r_k] <= ONE_Q16 - {1'b0, h_v[30:15]};
                r_k      <= r_k + 2'd1;
            end
            ST_B1:  r_acc <= r_p[33:0];
            ST_B2:  r_a   <= sum_hi;
            ST_B3:  r_acc <= r_p[33:0];
            ST_B4:  r_b   <= sum_hi;
            ST_B5:  r_acc <= r_p[33:0];
            ST_ACC: begin
                r_sum <= r_sum + r_p[SUM_W-1:0];
                r_tot <= r_tot + TOT_W'(r_amp);
            end
            ST_NX:  r_amp <= r_p[AMP_W+14:15];
            ST_NF: begin
                r_freq <= (r_p[67:44] != '0) ? 32'hffff_ffff : r_p[43:12];
                r_oct  <= r_oct + 1'b1;
            end
            default: ;
        endcase
    end

    // y pass: first x blend from r_a in state b4, second from r_b in state b5

    assign o_done = (r_state == ST_DONE);
    assign o_sum  = r_sum;
    assign o_tot  = r_tot;

endmodule

// ===== sv/fbm_value_noise_2d_top.sv =====
// ----------------------------------------------------------------------------
// fbm_value_noise_2d_top: fractal value noise, 2d, fixed point
// octave sequencer followed by a chain of restoring division cells
// ----------------------------------------------------------------------------
// path from input transfer to result valid: the octave sequencer states for each
//   octave, the finish state, 17 division cells and 1 output register
// one item at a time: a new input is taken only after the result transfer;
//   the shared multiplier in the octave sequencer sets the per-octave cost
// reset (synchronous, active low): config returns to 4 octaves, lacunarity 2.0,
//   gain 0.5; all control and valid state is cleared
module fbm_value_noise_2d_top #(
    parameter int unsigned MAX_OCTAVES     = 8,
    parameter int unsigned COORD_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [31:0]          i_pos_x,
    input  logic signed [31:0]          i_pos_y,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fbm_pkg::NOISE_W-1:0] o_noise_value,
    // config write port
    input  logic                        i_cfg_we,
    input  logic [fbm_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [fbm_pkg::CFG_W-1:0]   i_cfg_data
);
    import fbm_pkg::*;

    localparam int unsigned OCT_W = $clog2(MAX_OCTAVES + 1);
    // amplitude grows by less than 2x per octave from 1.0 in q1.15
    localparam int unsigned AMP_W = 16 + MAX_OCTAVES;
    localparam int unsigned TOT_W = AMP_W + $clog2(MAX_OCTAVES + 1);
    localparam int unsigned SUM_W = TOT_W + NOISE_W;
    localparam int unsigned NCELL = NOISE_W;

    // config registers
    logic [3:0]          r_octave_count;
    logic [15:0]         r_lacunarity;
    logic [15:0]         r_gain;
    logic [OCT_W-1:0]    eff_count;

    // handshake state
    logic                r_busy;
    logic                r_out_vld;
    logic [NOISE_W-1:0]  r_out;
    logic                in_xfer;
    logic                out_xfer;

    // sequencer results
    logic                seq_done;
    logic [SUM_W-1:0]    seq_sum;
    logic [TOT_W-1:0]    seq_tot;

    // division chain taps
    logic                dv_vld [NCELL+1];
    logic [SUM_W-1:0]    dv_rem [NCELL+1];
    logic [SUM_W-1:0]    dv_dsh [NCELL+1];
    logic [NOISE_W-1:0]  dv_q   [NCELL+1];
    logic [NCELL-1:0]    dv_vld_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= 4'd4;
            r_lacunarity   <= 16'd8192;
            r_gain         <= 16'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[3:0];
                REG_LACUNARITY:   r_lacunarity   <= i_cfg_data;
                REG_GAIN:         r_gain         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one octave, anything above the maximum as the maximum
    always_comb begin
        if (r_octave_count == 4'd0) begin
            eff_count = OCT_W'(1);
        end else if (32'(r_octave_count) > MAX_OCTAVES) begin
            eff_count = OCT_W'(MAX_OCTAVES);
        end else begin
            eff_count = OCT_W'(r_octave_count);
        end
    end

    assign o_in_ready = !r_busy;
    assign in_xfer    = i_in_valid && !r_busy;
    assign out_xfer   = r_out_vld && i_out_ready;

    // busy from input transfer until the result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_xfer) begin
            r_busy <= 1'b1;
        end else if (out_xfer) begin
            r_busy <= 1'b0;
        end
    end

    fbm_oct_seq #(
        .MAX_OCTAVES     (MAX_OCTAVES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .OCT_W           (OCT_W),
        .AMP_W           (AMP_W),
        .TOT_W           (TOT_W),
        .SUM_W           (SUM_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_xfer),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_count      (eff_count),
        .i_lacunarity (r_lacunarity),
        .i_gain       (r_gain),
        .o_done       (seq_done),
        .o_sum        (seq_sum),
        .o_tot        (seq_tot)
    );

    // quotient is at most 1.0 in q1.16, so the divisor starts shifted up by 16
    assign dv_vld[0] = seq_done;
    assign dv_rem[0] = seq_sum;
    assign dv_dsh[0] = SUM_W'(seq_tot) << (NOISE_W - 1);
    assign dv_q[0]   = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_div
        fbm_div_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dv_vld[g]),
            .i_rem   (dv_rem[g]),
            .i_dsh   (dv_dsh[g]),
            .i_q     (dv_q[g]),
            .o_vld   (dv_vld[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_dsh   (dv_dsh[g+1]),
            .o_q     (dv_q[g+1])
        );
        assign dv_vld_vec[g] = dv_vld[g+1];
    end

    // output register holds the result until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (dv_vld[NCELL]) begin
            r_out_vld <= 1'b1;
        end else if (out_xfer) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_vld[NCELL]) begin
            r_out <= dv_q[NCELL];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_noise_value = r_out;

`ifndef NO_ASSERTIONS
    // only one item is ever in the division chain
    a_one_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dv_vld_vec))
        else $error("more than one item in division chain");

    // a pending result means the input side is closed
    a_ready_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !o_in_ready)
        else $error("input ready while result pending");

    // normalized result never exceeds 1.0
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld[NCELL] |-> (dv_q[NCELL] <= ONE_Q16))
        else $error("noise value above one");
`endif

endmodule

// ===== tb/fbm_noise_checker.sv =====
// ----------------------------------------------------------------------------
// fbm_noise_checker: scoreboard for the fractal value noise block
// tracks config writes, predicts each noise value and compares on output
// ----------------------------------------------------------------------------
module fbm_noise_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic signed [31:0]          i_pos_x,
    input  logic signed [31:0]          i_pos_y,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [fbm_pkg::NOISE_W-1:0] i_noise_value,
    input  logic                        i_cfg_we,
    input  logic [fbm_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [fbm_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import fbm_pkg::*;

    localparam int unsigned OCT_LIMIT = 8;

    logic [3:0]  octaves_q;
    logic [15:0] lacunarity_q;
    logic [15:0] gain_q;
    logic [16:0] noise_queue[$];

    function automatic logic [63:0] lattice_value(logic [31:0] ix, logic [31:0] iy);
        logic [31:0] n;
        logic [31:0] n_sh;
        logic [31:0] h;
        n = ix * 32'd1619 + iy * 32'd31337;
        // arithmetic shift kept apart so the sign fill is not lost
        n_sh = $signed(n) >>> 13;
        n = n_sh ^ n;
        h = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
        return 64'd65536 - 64'(h >> 15);
    endfunction

    function automatic logic [63:0] fade(logic [63:0] f);
        logic [63:0] f2;
        f2 = (f * f) >> 16;
        return (f2 * (64'd196608 - 2 * f)) >> 16;
    endfunction

    function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        return (a * (64'd65536 - w) + b * w) >> 16;
    endfunction

    function automatic logic [63:0] octave_sample(logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic [63:0] freq);
        logic signed [63:0] prod_x;
        logic signed [63:0] prod_y;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [63:0] wx;
        logic [63:0] wy;
        logic [63:0] top_row;
        logic [63:0] bot_row;
        prod_x = 64'(px) * $signed(freq);
        prod_y = 64'(py) * $signed(freq);
        cx = prod_x[59:28];
        cy = prod_y[59:28];
        wx = fade(64'(prod_x[27:12]));
        wy = fade(64'(prod_y[27:12]));
        top_row = mix(lattice_value(cx, cy), lattice_value(cx + 1, cy), wx);
        bot_row = mix(lattice_value(cx, cy + 1), lattice_value(cx + 1, cy + 1), wx);
        return mix(top_row, bot_row, wy);
    endfunction

    function automatic logic [16:0] fbm_noise(logic signed [31:0] px, logic signed [31:0] py);
        int unsigned count;
        logic [63:0] freq;
        logic [63:0] amp;
        logic [63:0] acc;
        logic [63:0] amp_sum;
        logic [63:0] quot;
        count = octaves_q;
        freq = 64'd4096;
        amp = 64'd32768;
        acc = 0;
        amp_sum = 0;
        if (count < 1) count = 1;
        if (count > OCT_LIMIT) count = OCT_LIMIT;
        for (int i = 0; i < count; i++) begin
            acc += octave_sample(px, py, freq) * amp;
            amp_sum += amp;
            amp = (amp * gain_q) >> 15;
            freq = (freq * lacunarity_q) >> 12;
            if (freq > 64'hffff_ffff) freq = 64'hffff_ffff;
        end
        quot = acc / amp_sum;
        return quot[16:0];
    endfunction

    assign o_pending = noise_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            octaves_q    <= 4'd4;
            lacunarity_q <= 16'd8192;
            gain_q       <= 16'd16384;
        end else begin
            // prediction uses the config in force before this edge's write
            if (i_in_valid && i_in_ready)
                noise_queue.push_back(fbm_noise(i_pos_x, i_pos_y));
            if (i_out_valid && i_out_ready) begin
                if (noise_queue.size() == 0) begin
                    $error("noise_value: unexpected transfer, actual %0d", i_noise_value);
                    o_fail_count <= o_fail_count + 1;
                end else if (noise_queue[0] !== i_noise_value) begin
                    $error("noise_value: expected %0d, actual %0d", noise_queue[0],
                           i_noise_value);
                    o_fail_count <= o_fail_count + 1;
                    void'(noise_queue.pop_front());
                end else begin
                    void'(noise_queue.pop_front());
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OCTAVE_COUNT: octaves_q    <= i_cfg_data[3:0];
                    REG_LACUNARITY:   lacunarity_q <= i_cfg_data;
                    REG_GAIN:         gain_q       <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb_fbm_value_noise_2d_top.sv =====
// ----------------------------------------------------------------------------
// tb_fbm_value_noise_2d_top: testbench for the fractal value noise block
// drives positions through several config phases with random stalls on both
// channels; a side checker predicts every noise value and counts mismatches
// ----------------------------------------------------------------------------
module tb_fbm_value_noise_2d_top;
    import fbm_pkg::*;

    // index past the end of the register list, writes must be dropped
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 183;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [31:0]    i_pos_x;
    logic signed [31:0]    i_pos_y;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [NOISE_W-1:0]    o_noise_value;
    logic                  i_cfg_we;
    logic [IDX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    int                    fail_count;
    int                    pending;
    logic                  stim_done;

    // per-phase settings: octaves, lacunarity, gain
    logic [15:0] phase_oct[NUM_PHASES] = '{4, 1, 8, 0, 15, 9, 2, 3, 8, 5};
    logic [15:0] phase_lac[NUM_PHASES] =
        '{8192, 0, 65535, 4096, 12345, 0, 1, 6000, 8192, 16'hffff};
    logic [15:0] phase_gain[NUM_PHASES] =
        '{16384, 0, 65535, 32768, 40000, 65535, 1, 20000, 0, 16'hffff};

    fbm_value_noise_2d_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_noise_value (o_noise_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    fbm_noise_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_noise_value (o_noise_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 94) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // random position: full range, near the origin, or near the extremes
    function automatic logic [31:0] pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r < 8) return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        if (r == 8) return 32'h8000_0000 + $urandom_range(0, 255);
        return 32'h7fff_ffff - $urandom_range(0, 255);
    endfunction

    // one input transfer; valid stays high when no gap follows
    task automatic send_pos(logic [31:0] x, logic [31:0] y);
        int gap;
        i_in_valid <= 1'b1;
        i_pos_x    <= x;
        i_pos_y    <= y;
        do @(posedge i_clk); while (!o_in_ready);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // back-to-back register writes, including a dropped out-of-range index
    task automatic write_config(logic [15:0] oct, logic [15:0] lac, logic [15:0] gn);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_UNUSED;
        i_cfg_data <= 16'h0001;
        @(posedge i_clk);
        i_cfg_idx  <= REG_OCTAVE_COUNT;
        i_cfg_data <= oct;
        @(posedge i_clk);
        i_cfg_idx  <= REG_LACUNARITY;
        i_cfg_data <= lac;
        @(posedge i_clk);
        i_cfg_idx  <= REG_GAIN;
        i_cfg_data <= gn;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // drain: wait for every transfer out, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // output side: ready runs high and low for random lengths
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            i_out_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        stim_done  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners with the reset config
        send_pos(32'h0000_0000, 32'h0000_0000);
        send_pos(32'h7fff_ffff, 32'h7fff_ffff);
        send_pos(32'h8000_0000, 32'h8000_0000);
        send_pos(32'h7fff_ffff, 32'h8000_0000);
        send_pos(32'hffff_ffff, 32'hffff_ffff);
        send_pos(32'h0000_8000, 32'h0000_ffff);
        send_pos(32'h0001_0000, 32'hffff_0000);
        send_pos(32'h0000_0001, 32'hffff_8000);
        send_pos(32'h5555_5555, 32'haaaa_aaaa);
        send_pos(32'haaaa_aaaa, 32'h5555_5555);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain();
                // last phases pick their settings at random
                if (p >= 8) write_config(16'($urandom_range(0, 15)), 16'($urandom),
                                         16'($urandom));
                else write_config(phase_oct[p], phase_lac[p], phase_gain[p]);
                // edge positions under each new setting
                send_pos(32'h7fff_ffff, 32'h8000_0000);
                send_pos(32'h8000_0000, 32'h0000_ffff);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_pos(pick_pos(), pick_pos());
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        stim_done = 1'b1;
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #60000000;
        if (!stim_done) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
